FILE: hdl/rotated_framebuffer_dirty_tracker_defines.svh
// Assertion helpers for the dirty tracker.
`ifndef ROTATED_FRAMEBUFFER_DIRTY_TRACKER_DEFINES_SVH
`define ROTATED_FRAMEBUFFER_DIRTY_TRACKER_DEFINES_SVH

// same-cycle implication
`define RFDT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rfdt check failed");

// next-cycle implication
`define RFDT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rfdt check failed");

`endif

FILE: hdl/rfdt_pkg.sv
package rfdt_pkg;

   localparam int NATIVE_ROW_BYTES = 16;
   localparam int NATIVE_ROWS      = 250;
   localparam int CANVAS_ROW_BYTES = 32;

   localparam int STORE_DEPTH  = 4096;
   localparam int ADDR_W       = 12;
   localparam int TOTAL_BYTES  = NATIVE_ROW_BYTES * NATIVE_ROWS;
   localparam int NATIVE_COLS  = NATIVE_ROW_BYTES * 8;
   localparam int THR_FULL     = TOTAL_BYTES * 3 / 4;
   localparam int THR_FAST     = TOTAL_BYTES / 2;

   localparam logic [2:0] ACT_NONE      = 3'd0;
   localparam logic [2:0] ACT_FULL      = 3'd1;
   localparam logic [2:0] ACT_FAST_ALL  = 3'd2;
   localparam logic [2:0] ACT_FAST_PART = 3'd3;
   localparam logic [2:0] ACT_NOT_READY = 3'd4;

   localparam logic MODE_CANVAS = 1'b0;
   localparam logic MODE_NATIVE = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [11:0] byte_index;
      logic [7:0]  byte_value;
      logic        last;
      logic        want_full;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  start_col_byte;
      logic [7:0]  start_row;
      logic [7:0]  width_pixels;
      logic [8:0]  height_rows;
      logic [12:0] area_bytes;
   } rsp_word_type;

endpackage

FILE: hdl/rotated_framebuffer_dirty_tracker.sv
// Dirty-rectangle tracker for a rotated 1-bit panel. Frame store and canvas
// shadow live in two 4096 x 8 RAMs, each with one write port and one
// registered read port. After reset both are swept to 0xFF with req_ready
// low; after every native frame end (while enabled) the shadow alone is swept
// again. A native word is compared and written whole; a canvas word steps
// through its bit positions, and each changed bit that lands on the panel
// is a read-modify-write on the frame store RAM.
// A result waits in an output register; a later last word stalls only
// if that register is still full.
`include "rotated_framebuffer_dirty_tracker_defines.svh"

module rotated_framebuffer_dirty_tracker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rfdt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rfdt_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SHRD, S_BIT, S_BWR, S_NWR, S_FIN
   } state_type;

   state_type              state_ff;
   rfdt_pkg::req_word_type item_ff;
   logic [7:0]             diff_ff;
   logic [2:0]             bit_ff;
   logic [11:0]            clr_cnt_ff;
   logic                   clr_both_ff;
   logic                   enabled_ff;
   logic                   any_dirty_ff;
   logic [7:0]             min_row_ff, max_row_ff;
   logic [3:0]             min_col_ff, max_col_ff;
   logic                   rsp_valid_ff;
   rfdt_pkg::rsp_word_type rsp_ff;

   logic       req_fire;
   logic [7:0] sh_rdata, st_rdata;
   logic       sh_we, st_we;
   logic [11:0] sh_waddr, st_waddr, st_raddr;
   logic [7:0] sh_wdata, st_wdata;

   // canvas geometry of the held word
   logic [6:0]  ly;
   logic [4:0]  bx;
   logic [6:0]  nx;
   logic [3:0]  col;
   logic [7:0]  setm;
   logic [9:0]  row_b;
   logic        bit_on;
   logic        bit_ok;
   logic [11:0] ni_b;
   logic [7:0]  new_rot;
   logic [7:0]  diff_now;

   // box update
   logic        upd;
   logic [11:0] upd_addr;
   logic [7:0]  upd_r;
   logic [3:0]  upd_c;

   // result
   logic [4:0]  res_w;
   logic [8:0]  res_h;
   logic [12:0] res_area;
   logic [2:0]  res_act;
   rfdt_pkg::rsp_word_type rsp_in;
   logic        rsp_load;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign ly     = 7'(item_ff.byte_index / rfdt_pkg::CANVAS_ROW_BYTES);
   assign bx     = 5'(item_ff.byte_index % rfdt_pkg::CANVAS_ROW_BYTES);
   assign nx     = 7'(rfdt_pkg::NATIVE_COLS - 1 - int'(ly));
   assign col    = nx[6:3];
   assign setm   = 8'h80 >> nx[2:0];
   assign row_b  = {2'b00, bx, 3'b000} + {7'd0, bit_ff};
   assign bit_on = item_ff.byte_value[3'd7 - bit_ff];
   assign bit_ok = diff_ff[3'd7 - bit_ff] && (row_b < 10'(rfdt_pkg::NATIVE_ROWS));
   assign ni_b   = 12'(row_b * rfdt_pkg::NATIVE_ROW_BYTES + int'(col));
   assign new_rot  = bit_on ? (st_rdata | setm) : (st_rdata & ~setm);
   assign diff_now = sh_rdata ^ item_ff.byte_value;

   rfdt_ram #(.DEPTH(rfdt_pkg::STORE_DEPTH), .WIDTH(8)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_addr(st_raddr), .rd_data(st_rdata)
   );

   rfdt_ram #(.DEPTH(rfdt_pkg::STORE_DEPTH), .WIDTH(8)) u_shadow (
      .clock(clock), .wr_en(sh_we), .wr_addr(sh_waddr), .wr_data(sh_wdata),
      .rd_addr(req_word.byte_index), .rd_data(sh_rdata)
   );

   always_comb begin
      st_raddr = (state_ff == S_BIT) ? ni_b : req_word.byte_index;
      sh_we    = 1'b0;
      sh_waddr = item_ff.byte_index;
      sh_wdata = item_ff.byte_value;
      st_we    = 1'b0;
      st_waddr = item_ff.byte_index;
      st_wdata = item_ff.byte_value;
      upd      = 1'b0;
      upd_addr = item_ff.byte_index;
      case (state_ff)
         S_CLEAR: begin
            sh_we    = 1'b1;
            sh_waddr = clr_cnt_ff;
            sh_wdata = 8'hFF;
            st_we    = clr_both_ff;
            st_waddr = clr_cnt_ff;
            st_wdata = 8'hFF;
         end
         S_SHRD: begin
            sh_we = 1'b1;
         end
         S_BWR: begin
            upd      = (new_rot != st_rdata);
            st_we    = upd;
            st_waddr = ni_b;
            st_wdata = new_rot;
            upd_addr = ni_b;
         end
         S_NWR: begin
            upd   = (item_ff.byte_value != st_rdata);
            st_we = upd;
         end
         default: begin
         end
      endcase
      upd_r = 8'(upd_addr / rfdt_pkg::NATIVE_ROW_BYTES);
      upd_c = 4'(upd_addr % rfdt_pkg::NATIVE_ROW_BYTES);
   end

   always_comb begin
      res_w    = {1'b0, max_col_ff} - {1'b0, min_col_ff} + 5'd1;
      res_h    = {1'b0, max_row_ff} - {1'b0, min_row_ff} + 9'd1;
      res_area = {8'd0, res_w} * {4'd0, res_h};
      if (item_ff.mode == rfdt_pkg::MODE_CANVAS) begin
         if (item_ff.want_full && (res_area > 13'(rfdt_pkg::THR_FULL))) res_act = rfdt_pkg::ACT_FULL;
         else if (res_area > 13'(rfdt_pkg::THR_FAST)) res_act = rfdt_pkg::ACT_FAST_ALL;
         else res_act = rfdt_pkg::ACT_FAST_PART;
      end else begin
         if (item_ff.want_full) res_act = rfdt_pkg::ACT_FULL;
         else if (res_area > 13'(rfdt_pkg::THR_FAST)) res_act = rfdt_pkg::ACT_FAST_ALL;
         else res_act = rfdt_pkg::ACT_FAST_PART;
      end
      rsp_in = '0;
      if (!enabled_ff) begin
         rsp_in.action = rfdt_pkg::ACT_NOT_READY;
      end else if (any_dirty_ff) begin
         rsp_in.action         = res_act;
         rsp_in.start_col_byte = min_col_ff;
         rsp_in.start_row      = min_row_ff;
         rsp_in.width_pixels   = {res_w, 3'b000};
         rsp_in.height_rows    = res_h;
         rsp_in.area_bytes     = res_area;
      end else begin
         rsp_in.action = rfdt_pkg::ACT_NONE;
      end
      rsp_load = (state_ff == S_FIN) && item_ff.last && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         clr_both_ff  <= 1'b1;
         enabled_ff   <= 1'b0;
         any_dirty_ff <= 1'b0;
         min_row_ff   <= 8'hFF;
         max_row_ff   <= 8'h00;
         min_col_ff   <= 4'hF;
         max_col_ff   <= 4'h0;
         rsp_valid_ff <= 1'b0;
         bit_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            enabled_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (upd) begin
            any_dirty_ff <= 1'b1;
            if (!any_dirty_ff) begin
               min_row_ff <= upd_r;
               max_row_ff <= upd_r;
               min_col_ff <= upd_c;
               max_col_ff <= upd_c;
            end else begin
               if (upd_r < min_row_ff) min_row_ff <= upd_r;
               if (upd_r > max_row_ff) max_row_ff <= upd_r;
               if (upd_c < min_col_ff) min_col_ff <= upd_c;
               if (upd_c > max_col_ff) max_col_ff <= upd_c;
            end
         end
         case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 12'd1;
               if (clr_cnt_ff == 12'(rfdt_pkg::STORE_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  item_ff <= req_word;
                  if (!enabled_ff) begin
                     state_ff <= S_FIN;
                  end else if (req_word.mode == rfdt_pkg::MODE_CANVAS) begin
                     state_ff <= S_SHRD;
                  end else if (int'(req_word.byte_index) < rfdt_pkg::TOTAL_BYTES) begin
                     state_ff <= S_NWR;
                  end else begin
                     state_ff <= S_FIN;
                  end
               end
            end
            S_SHRD: begin
               diff_ff <= diff_now;
               bit_ff  <= '0;
               if (diff_now == 8'd0 || int'(ly) >= rfdt_pkg::NATIVE_COLS) begin
                  state_ff <= S_FIN;
               end else begin
                  state_ff <= S_BIT;
               end
            end
            S_BIT: begin
               if (bit_ok) begin
                  state_ff <= S_BWR;
               end else if (bit_ff == 3'd7) begin
                  state_ff <= S_FIN;
               end else begin
                  bit_ff <= bit_ff + 3'd1;
               end
            end
            S_BWR: begin
               if (bit_ff == 3'd7) begin
                  state_ff <= S_FIN;
               end else begin
                  bit_ff   <= bit_ff + 3'd1;
                  state_ff <= S_BIT;
               end
            end
            S_NWR: begin
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (!item_ff.last) begin
                  state_ff <= S_IDLE;
               end else if (rsp_load) begin
                  rsp_ff       <= rsp_in;
                  any_dirty_ff <= 1'b0;
                  min_row_ff   <= 8'hFF;
                  max_row_ff   <= 8'h00;
                  min_col_ff   <= 4'hF;
                  max_col_ff   <= 4'h0;
                  if (enabled_ff && item_ff.mode == rfdt_pkg::MODE_NATIVE) begin
                     clr_cnt_ff  <= '0;
                     clr_both_ff <= 1'b0;
                     state_ff    <= S_CLEAR;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `RFDT_ASSERT_NOW(a_no_accept_in_clear, state_ff == S_CLEAR, !req_ready)
   `RFDT_ASSERT_NOW(a_none_has_no_box, rsp_valid && (rsp_word.action == rfdt_pkg::ACT_NONE || rsp_word.action == rfdt_pkg::ACT_NOT_READY), rsp_word.height_rows == 9'd0 && rsp_word.area_bytes == 13'd0)
   `RFDT_ASSERT_NEXT(a_disabled_skips_ram, req_fire && !enabled_ff, state_ff == S_FIN)
   `RFDT_ASSERT_NOW(a_store_write_marks_box, st_we && state_ff != S_CLEAR, upd)

endmodule

FILE: hdl/rfdt_ram.sv
module rfdt_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
